// ----- rtl/core/r2h_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package r2h_pkg;

  localparam int FRAC_BITS    = 8;
  localparam int QUO_W        = 8 + FRAC_BITS;
  localparam int REM_W        = 11;
  localparam int DVD_W        = REM_W + QUO_W;
  localparam int BITS_PER_STG = 2;
  localparam int DIV_STAGES   = (QUO_W + BITS_PER_STG - 1) / BITS_PER_STG;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HUE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_HIGH = 3'd5;

  localparam logic [7:0] HUE_LOW_RST  = 8'd120;
  localparam logic [7:0] HUE_HIGH_RST = 8'd190;
  localparam logic [7:0] SAT_LOW_RST  = 8'd0;
  localparam logic [7:0] SAT_HIGH_RST = 8'd255;
  localparam logic [7:0] VAL_LOW_RST  = 8'd0;
  localparam logic [7:0] VAL_HIGH_RST = 8'd235;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [15:0] hue_fx;
    logic [15:0] sat_fx;
    logic [7:0]  brightness;
    logic        in_range;
  } hsv_res_t;

  typedef struct packed {
    logic [7:0] hue_low;
    logic [7:0] hue_high;
    logic [7:0] sat_low;
    logic [7:0] sat_high;
    logic [7:0] val_low;
    logic [7:0] val_high;
  } bounds_t;

  // partial remainder, dividend bits shifting out / quotient bits shifting in
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] dq;
    logic [REM_W-1:0] divisor;
  } div_lane_t;

  typedef struct packed {
    div_lane_t  hue;
    div_lane_t  sat;
    logic [7:0] brightness;
  } div_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/r2h_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module r2h_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               up_valid,
  output logic              up_stall,
  input  r2h_pkg::pixel_t   up_pixel,
  output logic              dn_valid,
  input  wire               dn_stall,
  output r2h_pkg::div_item_t dn_item
);
  import r2h_pkg::*;

  logic              va_r, vb_r;
  logic              adv_a, adv_b;

  logic [7:0]        mx_a_r, d_a_r;
  logic signed [8:0] diff_a_r;
  sector_t           sec_a_r;

  logic [7:0]        mx_nxt, mn_nxt;
  logic signed [8:0] diff_nxt;
  sector_t           sec_nxt;

  logic [REM_W-1:0]  d6;
  logic signed [11:0] num_s;
  logic [REM_W-1:0]  num;
  logic [18:0]       hue_prod;
  logic [15:0]       sat_prod;
  logic [DVD_W-1:0]  hue_dvd, sat_dvd;
  div_item_t         item_nxt;
  div_item_t         item_r;

  assign adv_b    = ~vb_r | ~dn_stall;
  assign adv_a    = ~va_r | adv_b;
  assign up_stall = ~adv_a;
  assign dn_valid = vb_r;
  assign dn_item  = item_r;

  // stage A: extremes, sector and the signed channel difference
  always_comb begin
    mx_nxt = up_pixel.red;
    mn_nxt = up_pixel.red;
    if (up_pixel.green > mx_nxt) mx_nxt = up_pixel.green;
    if (up_pixel.blue  > mx_nxt) mx_nxt = up_pixel.blue;
    if (up_pixel.green < mn_nxt) mn_nxt = up_pixel.green;
    if (up_pixel.blue  < mn_nxt) mn_nxt = up_pixel.blue;
    priority if (up_pixel.red == mx_nxt) begin
      sec_nxt  = SEC_RED;
      diff_nxt = $signed({1'b0, up_pixel.green}) - $signed({1'b0, up_pixel.blue});
    end else if (up_pixel.green == mx_nxt) begin
      sec_nxt  = SEC_GREEN;
      diff_nxt = $signed({1'b0, up_pixel.blue}) - $signed({1'b0, up_pixel.red});
    end else begin
      sec_nxt  = SEC_BLUE;
      diff_nxt = $signed({1'b0, up_pixel.red}) - $signed({1'b0, up_pixel.green});
    end
  end

  // stage B: hue numerator, dividends and divisors
  always_comb begin
    d6 = REM_W'({d_a_r, 2'b00}) + REM_W'({d_a_r, 1'b0});
    unique case (sec_a_r)
      SEC_RED: begin
        num_s = 12'(diff_a_r);
        if (diff_a_r < 0) num_s = num_s + $signed({1'b0, d6});
      end
      SEC_GREEN: num_s = $signed(12'({d_a_r, 1'b0}))  + 12'(diff_a_r);
      SEC_BLUE:  num_s = $signed(12'({d_a_r, 2'b00})) + 12'(diff_a_r);
      default:   num_s = '0;
    endcase
    num      = num_s[REM_W-1:0];
    hue_prod = {num, 8'b0} - 19'(num);
    sat_prod = {d_a_r, 8'b0} - 16'(d_a_r);
    hue_dvd  = DVD_W'(hue_prod) << FRAC_BITS;
    sat_dvd  = DVD_W'(sat_prod) << FRAC_BITS;

    item_nxt.hue.rem     = hue_dvd[DVD_W-1:QUO_W];
    item_nxt.hue.dq      = hue_dvd[QUO_W-1:0];
    item_nxt.hue.divisor = (d_a_r == 8'd0) ? REM_W'(1) : d6;
    item_nxt.sat.rem     = sat_dvd[DVD_W-1:QUO_W];
    item_nxt.sat.dq      = sat_dvd[QUO_W-1:0];
    item_nxt.sat.divisor = (mx_a_r == 8'd0) ? REM_W'(1) : REM_W'(mx_a_r);
    item_nxt.brightness  = mx_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (adv_a) va_r <= up_valid;
      if (adv_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      mx_a_r   <= mx_nxt;
      d_a_r    <= mx_nxt - mn_nxt;
      sec_a_r  <= sec_nxt;
      diff_a_r <= diff_nxt;
    end
    if (adv_b) item_r <= item_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/r2h_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module r2h_div (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                up_valid,
  output logic               up_stall,
  input  r2h_pkg::div_item_t up_item,
  output logic               dn_valid,
  input  wire                dn_stall,
  output r2h_pkg::div_item_t dn_item
);
  import r2h_pkg::*;

  localparam int LAST = DIV_STAGES - 1;

  div_item_t             st_r   [DIV_STAGES];
  div_item_t             st_nxt [DIV_STAGES];
  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES-1:0] adv;

  // restoring division, one quotient bit per step
  function automatic div_lane_t lane_steps(div_lane_t ln, int unsigned first);
    logic [REM_W:0] trial;
    logic           ge;
    div_lane_t      res;
    res = ln;
    for (int unsigned j = 0; j < BITS_PER_STG; j++) begin
      if (first + j < QUO_W) begin
        trial   = {res.rem, res.dq[QUO_W-1]};
        ge      = (trial >= {1'b0, res.divisor});
        res.rem = ge ? REM_W'(trial - {1'b0, res.divisor}) : trial[REM_W-1:0];
        res.dq  = {res.dq[QUO_W-2:0], ge};
      end
    end
    return res;
  endfunction

  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) st_nxt[s] = up_item;
      else        st_nxt[s] = st_r[s-1];
      st_nxt[s].hue = lane_steps(st_nxt[s].hue, s * BITS_PER_STG);
      st_nxt[s].sat = lane_steps(st_nxt[s].sat, s * BITS_PER_STG);
    end
  end

  always_comb begin
    adv[LAST] = ~v_r[LAST] | ~dn_stall;
    for (int s = LAST - 1; s >= 0; s--) begin
      adv[s] = ~v_r[s] | adv[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        if (adv[s]) v_r[s] <= (s == 0) ? up_valid : v_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (adv[s]) st_r[s] <= st_nxt[s];
    end
  end

  assign up_stall = ~adv[0];
  assign dn_valid = v_r[LAST];
  assign dn_item  = st_r[LAST];

endmodule

`default_nettype wire

// ----- rtl/core/r2h_thresh.sv -----
`timescale 1ns / 1ps
`default_nettype none

module r2h_thresh (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                up_valid,
  output logic               up_stall,
  input  r2h_pkg::div_item_t up_item,
  input  r2h_pkg::bounds_t   bounds,
  output logic               dn_valid,
  input  wire                dn_stall,
  output r2h_pkg::hsv_res_t  dn_result
);
  import r2h_pkg::*;

  logic             out_valid_r;
  logic             adv;
  logic [QUO_W-1:0] hue_q, sat_q;
  logic             hue_ok, sat_ok, val_ok;
  hsv_res_t         res_nxt, res_r;

  assign adv      = ~out_valid_r | ~dn_stall;
  assign up_stall = ~adv;
  assign dn_valid = out_valid_r;
  assign dn_result = res_r;

  always_comb begin
    hue_q  = up_item.hue.dq;
    sat_q  = up_item.sat.dq;
    hue_ok = (hue_q >= (QUO_W'(bounds.hue_low) << FRAC_BITS)) &&
             (hue_q <= (QUO_W'(bounds.hue_high) << FRAC_BITS));
    sat_ok = (sat_q >= (QUO_W'(bounds.sat_low) << FRAC_BITS)) &&
             (sat_q <= (QUO_W'(bounds.sat_high) << FRAC_BITS));
    val_ok = (up_item.brightness >= bounds.val_low) &&
             (up_item.brightness <= bounds.val_high);
    res_nxt.hue_fx     = 16'(hue_q);
    res_nxt.sat_fx     = 16'(sat_q);
    res_nxt.brightness = up_item.brightness;
    res_nxt.in_range   = hue_ok && sat_ok && val_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res_r <= res_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/rgb_to_hsv_range_classifier.sv -----
`timescale 1ns / 1ps
`default_nettype none

// RGB pixel to HSV converter with an HSV box threshold.
// Input channel: in_valid / in_stall carrying one pixel (blue, green, red).
// Result channel: out_valid / out_stall carrying hue_fx and sat_fx (Q8.8),
// brightness (the largest channel) and the in_range mask bit.
// Configuration: cfg_wr_en with cfg_index 0..5 writes hue, saturation and
// value bounds; other indexes are ignored. Write bounds only while idle.
// The pipeline holds two front stages, eight divider stages and the
// output register. Throughput is one item per cycle unless out_stall
// holds the output; the hue and saturation divisions run side by side in
// an 8-stage restoring divider that retires two quotient bits per stage.
// A stalled result holds in the output register; bubbles upstream still
// close up, so items are taken until every stage is full, then in_stall
// rises. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// default bounds: hue 120..190, saturation 0..255, value 0..235.
module rgb_to_hsv_range_classifier (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  r2h_pkg::pixel_t                       in_pixel,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output r2h_pkg::hsv_res_t                     out_result,
  input  wire                                   cfg_wr_en,
  input  wire [r2h_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire [r2h_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import r2h_pkg::*;

  bounds_t   bnd_r;
  logic      fr_valid, fr_stall, dv_valid, dv_stall;
  div_item_t fr_item, dv_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_r.hue_low  <= HUE_LOW_RST;
      bnd_r.hue_high <= HUE_HIGH_RST;
      bnd_r.sat_low  <= SAT_LOW_RST;
      bnd_r.sat_high <= SAT_HIGH_RST;
      bnd_r.val_low  <= VAL_LOW_RST;
      bnd_r.val_high <= VAL_HIGH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HUE_LOW:  bnd_r.hue_low  <= cfg_data;
        CFG_HUE_HIGH: bnd_r.hue_high <= cfg_data;
        CFG_SAT_LOW:  bnd_r.sat_low  <= cfg_data;
        CFG_SAT_HIGH: bnd_r.sat_high <= cfg_data;
        CFG_VAL_LOW:  bnd_r.val_low  <= cfg_data;
        CFG_VAL_HIGH: bnd_r.val_high <= cfg_data;
        default: ;
      endcase
    end
  end

  r2h_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_pixel (in_pixel),
    .dn_valid (fr_valid),
    .dn_stall (fr_stall),
    .dn_item  (fr_item)
  );

  r2h_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fr_valid),
    .up_stall (fr_stall),
    .up_item  (fr_item),
    .dn_valid (dv_valid),
    .dn_stall (dv_stall),
    .dn_item  (dv_item)
  );

  r2h_thresh u_thresh (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (dv_valid),
    .up_stall  (dv_stall),
    .up_item   (dv_item),
    .bounds    (bnd_r),
    .dn_valid  (out_valid),
    .dn_stall  (out_stall),
    .dn_result (out_result)
  );

endmodule

`default_nettype wire

// ----- rtl/core/r2h_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module r2h_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input wire                out_valid,
  input wire                out_stall,
  input r2h_pkg::hsv_res_t  out_result
);
  import r2h_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output stage is empty");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.brightness == 8'd0 |->
      out_result.sat_fx == 16'd0 && out_result.hue_fx == 16'd0)
    else $error("black pixel with non-zero hue or saturation");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.sat_fx == 16'd0 |-> out_result.hue_fx == 16'd0)
    else $error("grey pixel with non-zero hue");

endmodule

bind rgb_to_hsv_range_classifier r2h_checker u_chk (.*);

`default_nettype wire
